/* rtl/core/kvt_pkg.sv */
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_GET    = 2'd2,
    CMD_COUNT  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic key_hit;
    logic val_hit;
  } cell_hit_t;

endpackage

/* rtl/core/kvt_cell.sv */
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS
) (
  input  logic                  clk,
  input  kvt_pkg::cell_ctl_t    ctl,
  input  logic                  occupied,
  input  logic [KEY_BITS-1:0]   new_key,
  input  logic [VALUE_BITS-1:0] new_val,
  input  logic [KEY_BITS-1:0]   nb_key,
  input  logic [VALUE_BITS-1:0] nb_val,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [VALUE_BITS-1:0] cmp_val,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o,
  output kvt_pkg::cell_hit_t    hit
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= new_key;
      val_r <= new_val;
    end else if (ctl.shift) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end
  end

  assign key_o       = key_r;
  assign val_o       = val_r;
  assign hit.key_hit = occupied && (key_r == cmp_key);
  assign hit.val_hit = occupied && (val_r == cmp_val);

endmodule

/* rtl/core/keyed_value_table.sv */
`timescale 1ns / 1ps

// Keyed table of up to TABLE_DEPTH key/value pairs, packed in insertion order
// in a row of cells that each compare their own entry against the item.
// Items enter on the in_ channel: a command (insert, erase, get, count), a
// key and a value. Each item yields exactly one result on the out_ channel
// with a status, the value found by get, the match count for count and the
// occupancy after the command.
// For insert, erase and get the item is registered at the accepting edge;
// in the compare state every cell compares in parallel, and once the output
// register is free the table is updated and the result is registered; erase
// moves all later entries down one cell at once. Count captures the per-cell
// value matches and shifts them out of a bit chain one cell per cycle until
// no match is left, then waits in a final state for the output register.
// One item is processed at a time; a new item is accepted once the previous
// one has reached the output register, even while that result still waits,
// so items never overlap inside the table.
// When the receiver stalls, the result holds in the output register and the
// next item waits in its last stage until the register frees.
// Reset empties the table and drops any pending result at once; no clearing
// pass is needed since only occupied cells take part in compares.

module keyed_value_table #(
  parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH,
  parameter int KEY_BITS    = kvt_pkg::KEY_BITS,
  parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cmd[1:0], key[33:2], value[65:34], zero fill
  input  logic [kvt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[1:0], value_out[33:2], match_count[38:34], occupancy[43:39], zero fill
  output logic [kvt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int WW  = (CW > kvt_pkg::COUNT_W) ? CW : kvt_pkg::COUNT_W;
  localparam int LVL = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_COUNT = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [kvt_pkg::CMD_W-1:0] cmd_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [VALUE_BITS-1:0]     val_r;

  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          mcnt_r, mcnt_nxt;
  logic [TABLE_DEPTH-1:0] sr_r, sr_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [kvt_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [kvt_pkg::VALUE_W-1:0]     vout_r, vout_nxt;
  logic [kvt_pkg::COUNT_W-1:0]     mout_r, mout_nxt;
  logic [kvt_pkg::COUNT_W-1:0]     occ_r, occ_nxt;

  logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
  logic [VALUE_BITS-1:0]  cell_val [TABLE_DEPTH];
  kvt_pkg::cell_hit_t     cell_hit [TABLE_DEPTH];
  kvt_pkg::cell_ctl_t     cell_ctl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] key_hits, val_hits, after_hit;

  logic                  in_acc, out_free, any_hit, full;
  logic                  do_insert, do_erase;
  logic [VALUE_BITS-1:0] hit_val;
  logic [WW-1:0]         count_ext, mcnt_ext;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CW'(TABLE_DEPTH));

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]   nb_key;
      logic [VALUE_BITS-1:0] nb_val;
      if (i == TABLE_DEPTH - 1) begin : g_last
        assign nb_key = cell_key[i];
        assign nb_val = cell_val[i];
      end else begin : g_mid
        assign nb_key = cell_key[i+1];
        assign nb_val = cell_val[i+1];
      end

      assign cell_ctl[i].load  = do_insert && (count_r == CW'(i));
      assign cell_ctl[i].shift = do_erase && after_hit[i];

      kvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .occupied (CW'(i) < count_r),
        .new_key  (key_r),
        .new_val  (val_r),
        .nb_key   (nb_key),
        .nb_val   (nb_val),
        .cmp_key  (key_r),
        .cmp_val  (val_r),
        .key_o    (cell_key[i]),
        .val_o    (cell_val[i]),
        .hit      (cell_hit[i])
      );

      assign key_hits[i] = cell_hit[i].key_hit;
      assign val_hits[i] = cell_hit[i].val_hit;
    end
  endgenerate

  always_comb begin
    after_hit = key_hits;
    for (int l = 0; l < LVL; l++) begin
      after_hit = after_hit | (after_hit << (1 << l));
    end
  end

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_val = hit_val | (key_hits[i] ? cell_val[i] : '0);
    end
  end

  assign any_hit   = |key_hits;
  assign count_ext = WW'(count_nxt);
  assign mcnt_ext  = WW'(mcnt_r);

  assign do_insert = (state_r == S_EXEC) && out_free && (cmd_r == kvt_pkg::CMD_INSERT)
                     && !full && !any_hit;
  assign do_erase  = (state_r == S_EXEC) && out_free && (cmd_r == kvt_pkg::CMD_ERASE)
                     && any_hit;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mcnt_nxt      = mcnt_r;
    sr_nxt        = sr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    vout_nxt      = vout_r;
    mout_nxt      = mout_r;
    occ_nxt       = occ_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == kvt_pkg::CMD_COUNT) begin
          sr_nxt    = val_hits;
          mcnt_nxt  = '0;
          state_nxt = S_COUNT;
        end else if (out_free) begin
          status_nxt = kvt_pkg::ST_OK;
          vout_nxt   = '0;
          case (cmd_r)
            kvt_pkg::CMD_INSERT: begin
              if (full) begin
                status_nxt = kvt_pkg::ST_FULL;
              end else if (any_hit) begin
                status_nxt = kvt_pkg::ST_DUP;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            kvt_pkg::CMD_ERASE: begin
              if (!any_hit) begin
                status_nxt = kvt_pkg::ST_MISSING;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: begin
              if (!any_hit) begin
                status_nxt = kvt_pkg::ST_MISSING;
              end else begin
                vout_nxt = kvt_pkg::VALUE_W'(hit_val);
              end
            end
          endcase
          mout_nxt      = '0;
          occ_nxt       = count_ext[kvt_pkg::COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_COUNT: begin
        if (sr_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          mcnt_nxt = mcnt_r + CW'(sr_r[0]);
          sr_nxt   = sr_r >> 1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          status_nxt    = kvt_pkg::ST_OK;
          vout_nxt      = '0;
          mout_nxt      = mcnt_ext[kvt_pkg::COUNT_W-1:0];
          occ_nxt       = count_ext[kvt_pkg::COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tdata[1:0];
      key_r <= KEY_BITS'(in_tdata[33:2]);
      val_r <= VALUE_BITS'(in_tdata[65:34]);
    end
    mcnt_r   <= mcnt_nxt;
    sr_r     <= sr_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    mout_r   <= mout_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, occ_r, mout_r, vout_r, status_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("table occupancy exceeds depth");

  a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(key_hits))
    else $error("more than one occupied cell holds the same key");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted item did not enter the compare stage");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_EXEC |=> $stable(count_r))
    else $error("occupancy changed outside the update cycle");

endmodule

/* dv/keyed_value_table_tb.sv */
`timescale 1ns / 1ps

module keyed_value_table_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 80;
  localparam int POOL_KEYS   = 24;
  localparam int POOL_VALS   = 4;
  localparam logic [31:0] SAME_VALUE = 32'hA5A5_0F0F;
  localparam logic [31:0] KEY_BASE   = 32'h8000_0001;

  typedef struct packed {
    kvt_pkg::cmd_t                    cmd;
    logic [kvt_pkg::KEY_W-1:0]        key;
    logic [kvt_pkg::VALUE_W-1:0]      value;
  } table_op_t;

  typedef struct packed {
    kvt_pkg::status_t                 status;
    logic [kvt_pkg::VALUE_W-1:0]      value_out;
    logic [kvt_pkg::COUNT_W-1:0]      match_count;
    logic [kvt_pkg::COUNT_W-1:0]      occupancy;
  } table_reply_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [kvt_pkg::IN_DATA_W-1:0]    in_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [kvt_pkg::OUT_DATA_W-1:0]   out_tdata;

  table_op_t               op_on_bus = '0;
  table_op_t               ops_pending[$];
  table_reply_t            replies_due[$];

  logic [kvt_pkg::KEY_W-1:0]        stored_key[kvt_pkg::TABLE_DEPTH];
  logic [kvt_pkg::VALUE_W-1:0]      stored_value[kvt_pkg::TABLE_DEPTH];
  int                               fill_level = 0;

  logic [kvt_pkg::KEY_W-1:0]        key_pool[POOL_KEYS];
  logic [kvt_pkg::VALUE_W-1:0]      value_pool[POOL_VALS];

  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;
  logic                    pressure_armed = 1'b0;
  int                      hold_cycles = 0;
  int                      cycle_count = 0;
  int                      mismatches = 0;
  int                      replies_seen = 0;

  // cmd[1:0], key[33:2], value[65:34], zero fill
  assign in_tdata = {{(kvt_pkg::IN_DATA_W - kvt_pkg::CMD_W - kvt_pkg::KEY_W
                       - kvt_pkg::VALUE_W){1'b0}},
                     op_on_bus.value, op_on_bus.key, op_on_bus.cmd};

  keyed_value_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int find_slot(logic [kvt_pkg::KEY_W-1:0] key);
    int hit;
    hit = -1;
    for (int i = 0; i < fill_level; i++) begin
      if (hit < 0 && stored_key[i] == key) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  function automatic table_reply_t apply_op(table_op_t op);
    table_reply_t reply;
    int slot;
    reply = '0;
    reply.status = kvt_pkg::ST_OK;
    case (op.cmd)
      kvt_pkg::CMD_INSERT: begin
        if (fill_level >= kvt_pkg::TABLE_DEPTH) begin
          reply.status = kvt_pkg::ST_FULL;
        end else if (find_slot(op.key) >= 0) begin
          reply.status = kvt_pkg::ST_DUP;
        end else begin
          stored_key[fill_level] = op.key;
          stored_value[fill_level] = op.value;
          fill_level++;
        end
      end
      kvt_pkg::CMD_ERASE: begin
        slot = find_slot(op.key);
        if (slot < 0) begin
          reply.status = kvt_pkg::ST_MISSING;
        end else begin
          for (int i = slot; i < fill_level - 1; i++) begin
            stored_key[i] = stored_key[i + 1];
            stored_value[i] = stored_value[i + 1];
          end
          fill_level--;
        end
      end
      kvt_pkg::CMD_GET: begin
        slot = find_slot(op.key);
        if (slot < 0) begin
          reply.status = kvt_pkg::ST_MISSING;
        end else begin
          reply.value_out = stored_value[slot];
        end
      end
      default: begin
        for (int i = 0; i < fill_level; i++) begin
          if (stored_value[i] == op.value) begin
            reply.match_count++;
          end
        end
      end
    endcase
    reply.occupancy = kvt_pkg::COUNT_W'(fill_level);
    return reply;
  endfunction

  task automatic report_mismatch(string field, int idx, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %0h, expected %0h", idx, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        replies_due.push_back(apply_op(op_on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (ops_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          op_on_bus <= ops_pending.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (pressure_armed && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result", replies_seen, 32'(out_tdata), 32'd0);
        end else begin
          want = replies_due.pop_front();
          if (out_tdata[1:0] != want.status) begin
            report_mismatch("status", replies_seen, 32'(out_tdata[1:0]), 32'(want.status));
          end
          if (out_tdata[33:2] != want.value_out) begin
            report_mismatch("value_out", replies_seen, out_tdata[33:2], want.value_out);
          end
          if (out_tdata[38:34] != want.match_count) begin
            report_mismatch("match_count", replies_seen, 32'(out_tdata[38:34]),
                            32'(want.match_count));
          end
          if (out_tdata[43:39] != want.occupancy) begin
            report_mismatch("occupancy", replies_seen, 32'(out_tdata[43:39]),
                            32'(want.occupancy));
          end
        end
        replies_seen++;
      end
      out_tready <= !(pressure_armed && hold_cycles < HOLD_LEN) &&
                    ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_op(kvt_pkg::cmd_t cmd, logic [kvt_pkg::KEY_W-1:0] key,
                        logic [kvt_pkg::VALUE_W-1:0] value);
    table_op_t op;
    op.cmd = cmd;
    op.key = key;
    op.value = value;
    ops_pending.push_back(op);
  endtask

  task automatic add_random_ops(int n, int insert_pct, int erase_pct, int get_pct);
    int r;
    kvt_pkg::cmd_t cmd;
    logic [kvt_pkg::KEY_W-1:0] key;
    logic [kvt_pkg::VALUE_W-1:0] value;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        cmd = kvt_pkg::CMD_INSERT;
      end else if (r < insert_pct + erase_pct) begin
        cmd = kvt_pkg::CMD_ERASE;
      end else if (r < insert_pct + erase_pct + get_pct) begin
        cmd = kvt_pkg::CMD_GET;
      end else begin
        cmd = kvt_pkg::CMD_COUNT;
      end
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                         : $urandom();
      value = ($urandom_range(0, 99) < 70) ? value_pool[$urandom_range(0, POOL_VALS - 1)]
                                           : $urandom();
      add_op(cmd, key, value);
    end
  endtask

  task automatic drain();
    while (ops_pending.size() != 0 || in_tvalid || replies_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) begin
      key_pool[i] = $urandom();
    end
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = $urandom();
    value_pool[3] = $urandom();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_op(kvt_pkg::CMD_COUNT, 32'd0, SAME_VALUE);
    add_op(kvt_pkg::CMD_GET, 32'd0, 32'd0);
    add_op(kvt_pkg::CMD_ERASE, '1, 32'd0);
    add_op(kvt_pkg::CMD_INSERT, 32'd0, SAME_VALUE);
    add_op(kvt_pkg::CMD_INSERT, 32'd0, 32'd0);
    add_op(kvt_pkg::CMD_INSERT, '1, SAME_VALUE);
    for (int i = 0; i < kvt_pkg::TABLE_DEPTH - 2; i++) begin
      add_op(kvt_pkg::CMD_INSERT, KEY_BASE + i, SAME_VALUE);
    end
    add_op(kvt_pkg::CMD_COUNT, '1, SAME_VALUE);
    // A full table reports full even for a key that is already present.
    add_op(kvt_pkg::CMD_INSERT, 32'd0, 32'd7);
    add_op(kvt_pkg::CMD_ERASE, 32'd0, 32'd0);
    add_op(kvt_pkg::CMD_ERASE, KEY_BASE + 6, 32'd0);
    add_op(kvt_pkg::CMD_GET, KEY_BASE + 7, 32'd0);
    add_op(kvt_pkg::CMD_INSERT, 32'd5, '1);
    add_op(kvt_pkg::CMD_INSERT, 32'd6, 32'd0);
    add_op(kvt_pkg::CMD_COUNT, 32'd0, '1);
    drain();

    add_random_ops(230, 55, 15, 15);
    drain();

    send_idle_pct = 53;
    add_random_ops(230, 35, 25, 25);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 53;
    add_random_ops(230, 20, 45, 20);
    drain();

    send_idle_pct = 22;
    recv_stall_pct = 22;
    add_random_ops(220, 35, 25, 25);
    drain();

    // The receiver holds off while items keep coming, so the input backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_armed = 1'b1;
    add_random_ops(40, 35, 25, 25);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
